// ===== rtl/core/itoa_pkg.sv =====
// Shared types, constants and lookup functions for the integer to ASCII block.
// No dependencies.
package itoa_pkg;

  localparam int MAX_DIGITS = 32;
  localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
  localparam int IDX_W      = $clog2(MAX_DIGITS);
  localparam int DIGIT_W    = 6;
  localparam int RADIX_W    = 6;
  localparam int PADDR_W    = 3;

  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
  localparam logic [RADIX_W-1:0] RADIX_DEC   = 6'd10;

  localparam logic             REG_RADIX  = 1'b0;
  localparam logic [6:0]       CHAR_MINUS = 7'h2d;
  localparam logic [6:0]       CHAR_ZERO  = 7'h30;
  localparam logic [6:0]       CHAR_A     = 7'h61;
  localparam logic [DIGIT_W-1:0] DIGIT_NINE = 6'd9;
  localparam logic [DIGIT_W-1:0] DIGIT_TEN  = 6'd10;

  typedef struct packed {
    logic [31:0]        mag;
    logic               neg;
    logic [RADIX_W-1:0] base;
    logic [31:0]        recip;
  } job_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_MUL,
    B_FIX,
    B_SIGN,
    B_RD,
    B_LD
  } back_state_t;

  // floor(2^32 / base)
  function automatic logic [31:0] recip_of(input logic [RADIX_W-1:0] base);
    logic [31:0] r;
    unique case (base)
      6'd2:    r = 32'h80000000;
      6'd3:    r = 32'h55555555;
      6'd4:    r = 32'h40000000;
      6'd5:    r = 32'h33333333;
      6'd6:    r = 32'h2aaaaaaa;
      6'd7:    r = 32'h24924924;
      6'd8:    r = 32'h20000000;
      6'd9:    r = 32'h1c71c71c;
      6'd10:   r = 32'h19999999;
      6'd11:   r = 32'h1745d174;
      6'd12:   r = 32'h15555555;
      6'd13:   r = 32'h13b13b13;
      6'd14:   r = 32'h12492492;
      6'd15:   r = 32'h11111111;
      6'd16:   r = 32'h10000000;
      6'd17:   r = 32'h0f0f0f0f;
      6'd18:   r = 32'h0e38e38e;
      6'd19:   r = 32'h0d79435e;
      6'd20:   r = 32'h0ccccccc;
      6'd21:   r = 32'h0c30c30c;
      6'd22:   r = 32'h0ba2e8ba;
      6'd23:   r = 32'h0b21642c;
      6'd24:   r = 32'h0aaaaaaa;
      6'd25:   r = 32'h0a3d70a3;
      6'd26:   r = 32'h09d89d89;
      6'd27:   r = 32'h097b425e;
      6'd28:   r = 32'h09249249;
      6'd29:   r = 32'h08d3dcb0;
      6'd30:   r = 32'h08888888;
      6'd31:   r = 32'h08421084;
      6'd32:   r = 32'h08000000;
      6'd33:   r = 32'h07c1f07c;
      6'd34:   r = 32'h07878787;
      6'd35:   r = 32'h07507507;
      6'd36:   r = 32'h071c71c7;
      default: r = 32'h80000000;
    endcase
    return r;
  endfunction

  function automatic logic [6:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [6:0] c;
    if (d > DIGIT_NINE) begin
      c = 7'(d - DIGIT_TEN) + CHAR_A;
    end else begin
      c = 7'(d) + CHAR_ZERO;
    end
    return c;
  endfunction

endpackage

// ===== rtl/core/itoa_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module itoa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/itoa_front.sv =====
// Front end: radix register on the APB port, input beat acceptance and sign/base classification.
// Depends on itoa_pkg.
module itoa_front import itoa_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  input  logic               value_valid,
  output logic               value_ready,
  input  logic signed [31:0] value,
  input  logic               q_full,
  output logic               push,
  output job_t               job
);

  logic [RADIX_W-1:0] radix;
  logic [RADIX_W-1:0] base;
  logic               neg;

  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= RADIX_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_RADIX) begin
      radix <= pwdata[RADIX_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_RADIX) ? {{(32-RADIX_W){1'b0}}, radix} : 32'd0;

  always_comb begin
    if (radix < RADIX_MIN) begin
      base = RADIX_MIN;
    end else if (radix > RADIX_MAX) begin
      base = RADIX_MAX;
    end else begin
      base = radix;
    end
  end

  assign neg         = (base == RADIX_DEC) && value[31];
  assign value_ready = !q_full && !rst;
  assign push        = value_valid && value_ready;

  always_comb begin
    job.mag   = neg ? (32'd0 - value) : value;
    job.neg   = neg;
    job.base  = base;
    job.recip = recip_of(base);
  end

endmodule

// ===== rtl/core/itoa_queue.sv =====
// Two-entry job queue between the front end and the conversion back end.
// Depends on itoa_pkg.
module itoa_queue import itoa_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t wjob,
  output logic full,
  input  logic pop,
  output logic empty,
  output job_t rjob
);

  job_t       entries [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] fill;

  assign full  = (fill == 2'd2);
  assign empty = (fill == 2'd0);
  assign rjob  = entries[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= wjob;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) begin
        wptr <= !wptr;
      end
      if (pop) begin
        rptr <= !rptr;
      end
      fill <= fill + 2'(push) - 2'(pop);
    end
  end

endmodule

// ===== rtl/core/itoa_back.sv =====
// Back end: digit extraction by reciprocal multiply, digit store, reverse-order emission.
// Depends on itoa_pkg and itoa_ram.
module itoa_back import itoa_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_empty,
  output logic       pop,
  input  job_t       qjob,
  output logic       char_valid,
  input  logic       char_ready,
  output logic [6:0] char_code,
  output logic       last_char
);

  back_state_t        state, state_next;
  logic [CNT_W-1:0]   count, count_next;
  logic [31:0]        mag, mag_next;
  logic               neg, neg_next;
  logic [RADIX_W-1:0] base, base_next;
  logic [31:0]        recip, recip_next;
  logic [31:0]        q_est;
  logic               q_est_load;

  logic [63:0]        prod;
  logic [31:0]        qb;
  logic [31:0]        rem_raw;
  logic               fix;
  logic [31:0]        rem_fix;
  logic [31:0]        q_fix;
  logic [CNT_W-1:0]   limit;
  logic [CNT_W-1:0]   cnt_m1;

  logic               ram_we;
  logic [DIGIT_W-1:0] ram_wdata;
  logic [DIGIT_W-1:0] ram_rdata;

  logic               slot_free;
  logic               out_load;
  logic [6:0]         out_char;
  logic               out_last;

  itoa_ram #(
    .WIDTH (DIGIT_W),
    .DEPTH (MAX_DIGITS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count[IDX_W-1:0]),
    .wdata (ram_wdata),
    .raddr (cnt_m1[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  assign prod      = 64'(mag) * 64'(recip);
  assign qb        = q_est * {{(32-RADIX_W){1'b0}}, base};
  assign rem_raw   = mag - qb;
  assign fix       = rem_raw >= {{(32-RADIX_W){1'b0}}, base};
  assign rem_fix   = fix ? rem_raw - {{(32-RADIX_W){1'b0}}, base} : rem_raw;
  assign q_fix     = q_est + 32'(fix);
  assign limit     = CNT_W'(MAX_DIGITS) - CNT_W'(neg);
  assign cnt_m1    = count - CNT_W'(1);
  assign slot_free = !char_valid || char_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    mag   <= mag_next;
    neg   <= neg_next;
    base  <= base_next;
    recip <= recip_next;
    if (q_est_load) begin
      q_est <= prod[63:32];
    end
  end

  always_comb begin
    state_next = state;
    count_next = count;
    mag_next   = mag;
    neg_next   = neg;
    base_next  = base;
    recip_next = recip;
    q_est_load = 1'b0;
    pop        = 1'b0;
    ram_we     = 1'b0;
    ram_wdata  = rem_fix[DIGIT_W-1:0];
    out_load   = 1'b0;
    out_char   = digit_char(ram_rdata);
    out_last   = (count == CNT_W'(1));
    unique case (state)
      B_IDLE: begin
        if (!q_empty) begin
          pop        = 1'b1;
          mag_next   = qjob.mag;
          neg_next   = qjob.neg;
          base_next  = qjob.base;
          recip_next = qjob.recip;
          count_next = '0;
          state_next = B_MUL;
        end
      end
      B_MUL: begin
        priority if (mag == 32'd0 && count == '0) begin
          ram_we     = 1'b1;
          ram_wdata  = '0;
          count_next = CNT_W'(1);
          state_next = B_SIGN;
        end else if (mag == 32'd0 || count >= limit) begin
          state_next = B_SIGN;
        end else begin
          q_est_load = 1'b1;
          state_next = B_FIX;
        end
      end
      B_FIX: begin
        ram_we     = 1'b1;
        count_next = count + CNT_W'(1);
        mag_next   = q_fix;
        state_next = B_MUL;
      end
      B_SIGN: begin
        if (!neg) begin
          state_next = B_RD;
        end else if (slot_free) begin
          out_load   = 1'b1;
          out_char   = CHAR_MINUS;
          out_last   = 1'b0;
          state_next = B_RD;
        end
      end
      B_RD: begin
        state_next = B_LD;
      end
      B_LD: begin
        if (slot_free) begin
          out_load   = 1'b1;
          count_next = cnt_m1;
          state_next = (count == CNT_W'(1)) ? B_IDLE : B_RD;
        end
      end
      default: begin
        state_next = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      char_valid <= 1'b0;
    end else if (out_load) begin
      char_valid <= 1'b1;
    end else if (char_ready) begin
      char_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      char_code <= out_char;
      last_char <= out_last;
    end
  end

  a_fix_rem: assert property (@(posedge clk) disable iff (rst)
    state == B_FIX |-> rem_fix < {{(32-RADIX_W){1'b0}}, base})
    else $error("digit remainder not below base");

  a_fix_count: assert property (@(posedge clk) disable iff (rst)
    state == B_FIX |=> count == $past(count) + CNT_W'(1) && state == B_MUL)
    else $error("digit count did not advance");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    state == B_LD && slot_free && count == CNT_W'(1) |=> state == B_IDLE && char_valid
      && last_char)
    else $error("final character not flagged");

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    state != B_IDLE |-> count <= CNT_W'(MAX_DIGITS))
    else $error("digit count beyond store depth");

endmodule

// ===== rtl/core/integer_to_ascii_radix.sv =====
// Top level of the integer to ASCII text converter.
// Depends on itoa_pkg, itoa_front, itoa_queue and itoa_back.
//
// Each input beat carries one signed 32-bit value; the block returns its text in the base held
// in the radix register (APB byte address 0, reset 10, values below 2 act as 2, above 36 as 36),
// one character per output beat, most significant digit first, last_char high on the final one.
// Base 10 prints a leading '-' for negative values; every other base reads the bits as unsigned.
// Per value: a dispatch state (B_IDLE), then per digit a reciprocal multiply (B_MUL) and a
// remainder correction (B_FIX) in the divide loop, a final B_MUL pass to finish the loop (a zero
// value takes only this pass), a sign slot (B_SIGN), which also loads the '-' when there is one,
// then per digit character a registered read of the digit store (B_RD) and a load (B_LD), plus
// any output stall. A two-entry queue in front lets new values be accepted while a conversion
// runs. No clearing pass is needed after reset.
module integer_to_ascii_radix import itoa_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               value_valid,
  output logic               value_ready,
  input  logic signed [31:0] value,
  output logic               char_valid,
  input  logic               char_ready,
  output logic [6:0]         char_code,
  output logic               last_char
);

  job_t wjob;
  job_t rjob;
  logic push;
  logic pop;
  logic q_full;
  logic q_empty;

  assign pready = 1'b1;

  itoa_front u_front (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .value_valid (value_valid),
    .value_ready (value_ready),
    .value       (value),
    .q_full      (q_full),
    .push        (push),
    .job         (wjob)
  );

  itoa_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wjob  (wjob),
    .full  (q_full),
    .pop   (pop),
    .empty (q_empty),
    .rjob  (rjob)
  );

  itoa_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .pop        (pop),
    .qjob       (rjob),
    .char_valid (char_valid),
    .char_ready (char_ready),
    .char_code  (char_code),
    .last_char  (last_char)
  );

endmodule

// ===== bench/tb_integer_to_ascii_radix.sv =====
// Testbench for integer_to_ascii_radix: directed and random values in many bases,
// checked character by character against a scoreboard that predicts each text.
// Depends on itoa_pkg and the integer_to_ascii_radix RTL.
`timescale 1ns / 100ps

class itoa_scoreboard;
  logic [5:0] radix;
  logic [7:0] pending_chars[$];  // {last_char, char_code}
  int failures;
  int values_seen;
  int chars_seen;

  function new();
    radix = itoa_pkg::RADIX_RESET;
    failures = 0;
    values_seen = 0;
    chars_seen = 0;
  endfunction

  task report(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    failures++;
  endtask

  function void note_config(input int index, input logic [31:0] data);
    if (index == int'(itoa_pkg::REG_RADIX)) begin
      radix = data[5:0];
    end
  endfunction

  function int pending();
    return pending_chars.size();
  endfunction

  // expand one value into its expected characters, most significant first
  function void note_value(input logic [31:0] v);
    logic [31:0] base;
    logic [31:0] mag;
    logic [5:0] digits [0:itoa_pkg::MAX_DIGITS-1];
    logic [6:0] ch;
    bit neg;
    int count;
    int limit;
    if (radix < itoa_pkg::RADIX_MIN) begin
      base = 32'(itoa_pkg::RADIX_MIN);
    end else if (radix > itoa_pkg::RADIX_MAX) begin
      base = 32'(itoa_pkg::RADIX_MAX);
    end else begin
      base = 32'(radix);
    end
    neg = (base == 32'(itoa_pkg::RADIX_DEC)) && v[31];
    mag = neg ? 32'd0 - v : v;
    limit = itoa_pkg::MAX_DIGITS - int'(neg);
    count = 0;
    if (mag == 32'd0) begin
      digits[0] = 6'd0;
      count = 1;
    end
    while (mag != 32'd0 && count < limit) begin
      digits[count] = 6'(mag % base);
      mag = mag / base;
      count++;
    end
    if (neg) begin
      pending_chars.push_back({1'b0, itoa_pkg::CHAR_MINUS});
    end
    for (int i = count; i > 0; i--) begin
      if (digits[i-1] > itoa_pkg::DIGIT_NINE) begin
        ch = itoa_pkg::CHAR_A + 7'(digits[i-1] - itoa_pkg::DIGIT_TEN);
      end else begin
        ch = itoa_pkg::CHAR_ZERO + 7'(digits[i-1]);
      end
      pending_chars.push_back({(i == 1), ch});
    end
    values_seen++;
  endfunction

  task check_char(input logic [6:0] code, input logic last);
    logic [7:0] want;
    chars_seen++;
    if (pending_chars.size() == 0) begin
      report($sformatf("unexpected char 0x%02h last=%0b", code, last));
      return;
    end
    want = pending_chars.pop_front();
    if (code !== want[6:0]) begin
      report($sformatf("char_code 0x%02h, expected 0x%02h", code, want[6:0]));
    end
    if (last !== want[7]) begin
      report($sformatf("last_char %0b, expected %0b on 0x%02h", last, want[7], want[6:0]));
    end
  endtask
endclass

module tb_integer_to_ascii_radix;
  import itoa_pkg::*;

  localparam logic [PADDR_W-1:0] RADIX_ADDR = PADDR_W'(4 * int'(REG_RADIX));
  localparam logic [PADDR_W-1:0] SPARE_ADDR = PADDR_W'(4);
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int PHASES           = 10;
  localparam int PHASE_VALUES     = 39;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel;
  logic penable;
  logic pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;
  logic value_valid;
  logic value_ready;
  logic signed [31:0] value;
  logic char_valid;
  logic char_ready;
  logic [6:0] char_code;
  logic last_char;

  itoa_scoreboard sb = new();
  bit quiet = 1'b0;
  bit long_hold = 1'b0;
  int radix_writes = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  integer_to_ascii_radix u_dut (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .value_valid (value_valid),
    .value_ready (value_ready),
    .value       (value),
    .char_valid  (char_valid),
    .char_ready  (char_ready),
    .char_code   (char_code),
    .last_char   (last_char)
  );

  function automatic int draw_gap();
    return quiet ? 0 : int'($urandom_range(0, 11));
  endfunction

  function automatic logic [31:0] rand_value();
    logic [31:0] v;
    case ($urandom_range(0, 6))
      0, 1: v = $urandom;
      2: v = $urandom_range(0, 40);
      3: v = 32'd0 - $urandom_range(1, 40);
      4: v = $urandom >> $urandom_range(0, 31);
      5: v = 32'd0 - ($urandom >> $urandom_range(0, 31));
      default: begin
        case ($urandom_range(0, 3))
          0: v = 32'h0000_0000;
          1: v = 32'h7fff_ffff;
          2: v = 32'h8000_0000;
          default: v = 32'hffff_ffff;
        endcase
      end
    endcase
    return v;
  endfunction

  task send_value(input logic [31:0] v);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      value_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    value_valid <= 1'b1;
    value <= v;
    do @(posedge clk); while (!value_ready);
    sb.note_value(v);
  endtask

  // drop valid and wait until every expected character is back
  task settle();
    value_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task apb_write(input logic [PADDR_W-1:0] addr, input logic [31:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    sb.note_config(int'(addr) / 4, data);
  endtask

  task apb_read(input logic [PADDR_W-1:0] addr, output logic [31:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= addr;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    data = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task check_radix();
    logic [31:0] rd;
    apb_read(RADIX_ADDR, rd);
    if (rd[5:0] !== sb.radix) begin
      sb.report($sformatf("radix reads %0d, expected %0d", rd[5:0], sb.radix));
    end
  endtask

  task set_radix(input logic [31:0] data);
    settle();
    apb_write(RADIX_ADDR, data);
    check_radix();
    radix_writes++;
  endtask

  // receiver: check each beat, then stall for a drawn number of cycles
  initial begin
    int stall_left;
    stall_left = 0;
    char_ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      @(posedge clk);
      if (char_valid && char_ready) begin
        sb.check_char(char_code, last_char);
        stall_left = draw_gap();
      end
      if (long_hold) begin
        stall_left = LONG_HOLD_CYCLES;
        long_hold = 1'b0;
      end
      if (stall_left > 0) begin
        char_ready <= 1'b0;
        stall_left--;
      end else begin
        char_ready <= 1'b1;
      end
    end
  end

  initial begin
    logic [5:0] phase_radix [0:5];
    logic [5:0] rad;
    phase_radix = '{6'd10, 6'd2, 6'd36, 6'd1, 6'd63, 6'd8};
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    value_valid <= 1'b0;
    value <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset base 10, sign handling and extremes
    check_radix();
    send_value(32'd0);
    send_value(32'd1);
    send_value(32'hffff_ffff);
    send_value(32'd9);
    send_value(32'd10);
    send_value(32'h7fff_ffff);
    send_value(32'h8000_0000);
    send_value(32'hffff_fff6);
    send_value(32'd123456789);
    // write to an unmapped register is ignored
    settle();
    apb_write(SPARE_ADDR, 32'd16);
    check_radix();
    send_value(32'hffff_fffb);
    set_radix(32'd2);
    send_value(32'd0);
    send_value(32'hffff_ffff);
    send_value(32'h8000_0000);
    send_value(32'd5);
    set_radix(32'h0000_0150);
    send_value(32'hdead_beef);
    set_radix(32'd36);
    send_value(32'd35);
    send_value(32'hffff_ffff);
    send_value(32'd36);
    set_radix(32'd0);
    send_value(32'd6);
    set_radix(32'd1);
    send_value(32'd3);
    set_radix(32'd37);
    send_value(32'd35);
    set_radix(32'd63);
    send_value(32'hffff_ffff);

    // random phases, one base each
    for (int k = 0; k < PHASES; k++) begin
      rad = (k < 6) ? phase_radix[k] : 6'($urandom_range(0, 63));
      set_radix({26'($urandom), rad});
      quiet = (k % 4 == 1);
      if (k == 1) begin
        long_hold = 1'b1;
      end
      for (int j = 0; j < PHASE_VALUES; j++) begin
        if (k == 3 && j == PHASE_VALUES / 2) begin
          settle();
        end
        send_value(rand_value());
      end
    end

    value_valid <= 1'b0;
    for (int n = 0; n < 200000 && sb.pending() != 0; n++) @(posedge clk);
    repeat (150) @(posedge clk);
    if (sb.pending() != 0) begin
      sb.report($sformatf("%0d characters never arrived", sb.pending()));
    end
    $display("Converted %0d values into %0d characters over %0d radix writes,",
             sb.values_seen, sb.chars_seen, radix_writes);
    $display("including out-of-range bases, sign cases and a long output hold-off.");
    if (sb.failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Timeout with %0d characters outstanding", sb.pending());
    $display("Some tests failed");
    $finish;
  end

endmodule
